// ===== hw/rtl/dai_pkg.sv =====
package dai_pkg;

	// Datapath sizing.
	localparam int RATE_BITS = 24;
	localparam int RATIO_FRAC_BITS = 16;
	localparam int RATIO_W = RATIO_FRAC_BITS + 1;
	localparam int CLK_W = 28;
	localparam int MS_W = 32;
	localparam int VAL_W = 16;
	localparam int CMP_W = 15;
	localparam int PROD_W = VAL_W + RATIO_W;

	// Shared divider: wide enough for the shifted excess and for the core clock.
	localparam int DIV_DW = (RATE_BITS + RATIO_FRAC_BITS > CLK_W) ?
		(RATE_BITS + RATIO_FRAC_BITS) : CLK_W;
	localparam int DIV_VW = (RATE_BITS > VAL_W) ? RATE_BITS : VAL_W;
	localparam int DIV_CW = $clog2(DIV_DW + 1);

	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = CLK_W;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_SLOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_FAST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CORE_CLOCK = 3'd4;

	// Reset values and limits.
	localparam logic [VAL_W-1:0] BLINK_SLOW_RST = 16'd500;
	localparam logic [VAL_W-1:0] BLINK_FAST_RST = 16'd150;
	localparam logic [VAL_W-1:0] TONE_LOW_RST = 16'd2700;
	localparam logic [VAL_W-1:0] TONE_HIGH_RST = 16'd6500;
	localparam logic [CLK_W-1:0] CORE_CLOCK_RST = 28'd72000000;
	localparam logic [VAL_W-1:0] TONE_MIN_HZ = 16'd1100;
	localparam logic [VAL_W-1:0] RELOAD_MAX = 16'hFFFF;

	// Input action codes.
	localparam logic ACT_REFRESH = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_RATIO_DIV = 6'b000010,
		ST_MUL_BLINK = 6'b000100,
		ST_MUL_TONE  = 6'b001000,
		ST_CLK_DIV   = 6'b010000,
		ST_FINISH    = 6'b100000
	} state_t;

	// Divider request and response.
	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_DW-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/dai_divider.sv =====
module dai_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  dai_pkg::div_req_t req,
	output dai_pkg::div_rsp_t rsp
);

	logic [dai_pkg::DIV_VW-1:0] rem_q;
	logic [dai_pkg::DIV_DW-1:0] quo_q;
	logic [dai_pkg::DIV_VW-1:0] divisor_q;
	logic [dai_pkg::DIV_CW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [dai_pkg::DIV_VW:0]   shifted;
	logic [dai_pkg::DIV_VW:0]   diff;
	logic                       fits;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		shifted = {rem_q, quo_q[dai_pkg::DIV_DW-1]};
		diff = shifted - {1'b0, divisor_q};
		fits = (shifted >= {1'b0, divisor_q});
	end

	// Control: count the quotient bits and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= dai_pkg::DIV_CW'(dai_pkg::DIV_DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dai_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[dai_pkg::DIV_VW-1:0] : shifted[dai_pkg::DIV_VW-1:0];
			quo_q <= {quo_q[dai_pkg::DIV_DW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hw/rtl/dose_alarm_intensity_driver.sv =====
// Ticks and refreshes with the alarm flag clear go from accept to the finish state, which
// loads the result once the output register is free. A refresh with the flag set runs up to
// two passes through the shared bit-serial divider: excess ratio, then clock / tone.
// The next item can be taken in the cycle after the result is loaded; a result may wait in
// the output register while the next item is taken. Reset clears the alarm state and
// loads the default configuration.
module dose_alarm_intensity_driver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dai_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dai_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic                              alarm_request,
	input  logic [dai_pkg::RATE_BITS-1:0]     measured_rate,
	input  logic [dai_pkg::RATE_BITS-1:0]     dose_threshold,
	input  logic [dai_pkg::MS_W-1:0]          now_ms,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              alarm_active,
	output logic                              led_lit,
	output logic                              tone_enable,
	output logic [dai_pkg::VAL_W-1:0]         reload_value,
	output logic [dai_pkg::CMP_W-1:0]         compare_value,
	output logic [dai_pkg::VAL_W-1:0]         blink_period_ms,
	output logic [dai_pkg::VAL_W-1:0]         tone_hz
);

	localparam int F = dai_pkg::RATIO_FRAC_BITS;
	localparam int RB = dai_pkg::RATE_BITS;

	dai_pkg::state_t state_q;

	// Configuration registers.
	logic [dai_pkg::VAL_W-1:0] blink_slow_q;
	logic [dai_pkg::VAL_W-1:0] blink_fast_q;
	logic [dai_pkg::VAL_W-1:0] tone_low_q;
	logic [dai_pkg::VAL_W-1:0] tone_high_q;
	logic [dai_pkg::CLK_W-1:0] core_clock_q;

	// Alarm state.
	logic                      alarm_on_q;
	logic [dai_pkg::VAL_W-1:0] blink_period_q;
	logic [dai_pkg::MS_W-1:0]  last_toggle_q;
	logic                      blink_phase_q;
	logic                      led_q;
	logic [dai_pkg::VAL_W-1:0] pwm_reload_q;
	logic [dai_pkg::CMP_W-1:0] pwm_compare_q;
	logic [dai_pkg::VAL_W-1:0] tone_freq_q;
	logic [dai_pkg::RATIO_W-1:0] ratio_q;

	// Output register.
	logic                      out_valid_q;
	logic                      out_alarm_q;
	logic                      out_led_q;
	logic [dai_pkg::VAL_W-1:0] out_reload_q;
	logic [dai_pkg::CMP_W-1:0] out_compare_q;
	logic [dai_pkg::VAL_W-1:0] out_blink_q;
	logic [dai_pkg::VAL_W-1:0] out_tone_q;

	logic                      in_take;
	logic                      out_free;
	logic [RB:0]               excess;
	logic [dai_pkg::VAL_W-1:0] fast_eff;
	logic [dai_pkg::VAL_W-1:0] high_eff;
	logic [dai_pkg::VAL_W-1:0] mul_a;
	logic [dai_pkg::PROD_W-1:0] product;
	logic [dai_pkg::VAL_W-1:0] delta;
	logic [dai_pkg::VAL_W-1:0] tone_raw;
	logic [dai_pkg::VAL_W-1:0] tone_clamped;
	logic [dai_pkg::MS_W-1:0]  elapsed;
	logic [dai_pkg::CLK_W-1:0] clk_quot;
	logic [dai_pkg::CLK_W-1:0] quot_m1;
	logic [dai_pkg::VAL_W-1:0] reload_sat;

	dai_pkg::div_req_t div_req;
	dai_pkg::div_rsp_t div_rsp;

	dai_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall = (state_q != dai_pkg::ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Refresh arithmetic around the shared multiplier.
	always_comb begin
		excess = {1'b0, measured_rate} - {1'b0, dose_threshold};
		fast_eff = (blink_fast_q > blink_slow_q) ? blink_slow_q : blink_fast_q;
		high_eff = (tone_high_q < tone_low_q) ? tone_low_q : tone_high_q;
		mul_a = (state_q == dai_pkg::ST_MUL_TONE) ? (high_eff - tone_low_q)
			: (blink_slow_q - fast_eff);
		product = dai_pkg::PROD_W'(mul_a) * dai_pkg::PROD_W'(ratio_q);
		delta = product[F + dai_pkg::VAL_W - 1:F];
		tone_raw = tone_low_q + delta;
		tone_clamped = (tone_raw < dai_pkg::TONE_MIN_HZ) ? dai_pkg::TONE_MIN_HZ : tone_raw;
		elapsed = now_ms - last_toggle_q;
		clk_quot = div_rsp.quotient[dai_pkg::CLK_W-1:0];
		quot_m1 = (clk_quot == '0) ? '0 : (clk_quot - 1'b1);
		reload_sat = (quot_m1 > dai_pkg::CLK_W'(dai_pkg::RELOAD_MAX)) ? dai_pkg::RELOAD_MAX
			: quot_m1[dai_pkg::VAL_W-1:0];
	end

	// Divider requests: the excess ratio on accept, the PWM reload after the tone.
	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = dai_pkg::DIV_DW'({excess[RB-1:0], {F{1'b0}}});
		div_req.divisor = dai_pkg::DIV_VW'(dose_threshold);
		if (state_q == dai_pkg::ST_MUL_TONE) begin
			div_req.start = 1'b1;
			div_req.dividend = dai_pkg::DIV_DW'(core_clock_q);
			div_req.divisor = dai_pkg::DIV_VW'(tone_clamped);
		end else if (in_take && action == dai_pkg::ACT_REFRESH && alarm_request
			&& dose_threshold != '0 && measured_rate > dose_threshold
			&& excess[RB-1:0] < dose_threshold) begin
			div_req.start = 1'b1;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_slow_q <= dai_pkg::BLINK_SLOW_RST;
			blink_fast_q <= dai_pkg::BLINK_FAST_RST;
			tone_low_q <= dai_pkg::TONE_LOW_RST;
			tone_high_q <= dai_pkg::TONE_HIGH_RST;
			core_clock_q <= dai_pkg::CORE_CLOCK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dai_pkg::CFG_BLINK_SLOW: begin
					blink_slow_q <= cfg_data[dai_pkg::VAL_W-1:0];
				end
				dai_pkg::CFG_BLINK_FAST: begin
					blink_fast_q <= cfg_data[dai_pkg::VAL_W-1:0];
				end
				dai_pkg::CFG_TONE_LOW: begin
					tone_low_q <= cfg_data[dai_pkg::VAL_W-1:0];
				end
				dai_pkg::CFG_TONE_HIGH: begin
					tone_high_q <= cfg_data[dai_pkg::VAL_W-1:0];
				end
				dai_pkg::CFG_CORE_CLOCK: begin
					core_clock_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer and alarm state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dai_pkg::ST_IDLE;
			alarm_on_q <= 1'b0;
			blink_period_q <= dai_pkg::BLINK_SLOW_RST;
			last_toggle_q <= '0;
			blink_phase_q <= 1'b0;
			led_q <= 1'b0;
			pwm_reload_q <= dai_pkg::RELOAD_MAX;
			pwm_compare_q <= '0;
			tone_freq_q <= '0;
			ratio_q <= '0;
		end else begin
			unique case (state_q)
				dai_pkg::ST_IDLE: begin
					if (in_take) begin
						if (action == dai_pkg::ACT_TICK) begin
							state_q <= dai_pkg::ST_FINISH;
							if (!alarm_on_q) begin
								led_q <= 1'b0;
								last_toggle_q <= '0;
								blink_phase_q <= 1'b0;
							end else if (elapsed >= dai_pkg::MS_W'(blink_period_q)) begin
								last_toggle_q <= now_ms;
								blink_phase_q <= !blink_phase_q;
								led_q <= !blink_phase_q;
							end
						end else if (!alarm_request) begin
							state_q <= dai_pkg::ST_FINISH;
							pwm_compare_q <= '0;
							tone_freq_q <= '0;
							led_q <= 1'b0;
							alarm_on_q <= 1'b0;
							blink_period_q <= blink_slow_q;
						end else if (div_req.start) begin
							state_q <= dai_pkg::ST_RATIO_DIV;
						end else begin
							// Ratio is zero without excess and saturates at full scale.
							state_q <= dai_pkg::ST_MUL_BLINK;
							if (dose_threshold == '0 || measured_rate <= dose_threshold) begin
								ratio_q <= '0;
							end else begin
								ratio_q <= dai_pkg::RATIO_W'(1) << F;
							end
						end
					end
				end
				dai_pkg::ST_RATIO_DIV: begin
					if (div_rsp.done) begin
						ratio_q <= div_rsp.quotient[dai_pkg::RATIO_W-1:0];
						state_q <= dai_pkg::ST_MUL_BLINK;
					end
				end
				dai_pkg::ST_MUL_BLINK: begin
					blink_period_q <= blink_slow_q - delta;
					state_q <= dai_pkg::ST_MUL_TONE;
				end
				dai_pkg::ST_MUL_TONE: begin
					tone_freq_q <= tone_clamped;
					state_q <= dai_pkg::ST_CLK_DIV;
				end
				dai_pkg::ST_CLK_DIV: begin
					if (div_rsp.done) begin
						pwm_reload_q <= reload_sat;
						pwm_compare_q <= reload_sat[dai_pkg::VAL_W-1:1];
						alarm_on_q <= 1'b1;
						state_q <= dai_pkg::ST_FINISH;
					end
				end
				dai_pkg::ST_FINISH: begin
					if (out_free) begin
						state_q <= dai_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= dai_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == dai_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: a snapshot of the state after the item.
	always_ff @(posedge clk) begin
		if (state_q == dai_pkg::ST_FINISH && out_free) begin
			out_alarm_q <= alarm_on_q;
			out_led_q <= led_q;
			out_reload_q <= pwm_reload_q;
			out_compare_q <= pwm_compare_q;
			out_blink_q <= blink_period_q;
			out_tone_q <= tone_freq_q;
		end
	end

	assign out_valid = out_valid_q;
	assign alarm_active = out_alarm_q;
	assign led_lit = out_led_q;
	assign tone_enable = out_alarm_q;
	assign reload_value = out_reload_q;
	assign compare_value = out_compare_q;
	assign blink_period_ms = out_blink_q;
	assign tone_hz = out_tone_q;

endmodule

// ===== tb/dose_alarm_intensity_driver_test.sv =====
`timescale 1ns / 1ps

module dose_alarm_intensity_driver_test;

	// One input item as the sender presents it.
	typedef struct {
		logic                          act;
		logic                          req;
		logic [dai_pkg::RATE_BITS-1:0] rate;
		logic [dai_pkg::RATE_BITS-1:0] thr;
		logic [dai_pkg::MS_W-1:0]      now;
	} dose_event_t;

	// One result item as the block should deliver it.
	typedef struct {
		logic                      alarm;
		logic                      led;
		logic                      tone_on;
		logic [dai_pkg::VAL_W-1:0] reload;
		logic [dai_pkg::CMP_W-1:0] compare;
		logic [dai_pkg::VAL_W-1:0] period;
		logic [dai_pkg::VAL_W-1:0] tone;
	} alarm_outputs_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [dai_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dai_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic                           action;
	logic                           alarm_request;
	logic [dai_pkg::RATE_BITS-1:0]  measured_rate;
	logic [dai_pkg::RATE_BITS-1:0]  dose_threshold;
	logic [dai_pkg::MS_W-1:0]       now_ms;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           alarm_active;
	logic                           led_lit;
	logic                           tone_enable;
	logic [dai_pkg::VAL_W-1:0]      reload_value;
	logic [dai_pkg::CMP_W-1:0]      compare_value;
	logic [dai_pkg::VAL_W-1:0]      blink_period_ms;
	logic [dai_pkg::VAL_W-1:0]      tone_hz;

	// Register copies kept by the predictor.
	logic [dai_pkg::VAL_W-1:0] reg_slow;
	logic [dai_pkg::VAL_W-1:0] reg_fast;
	logic [dai_pkg::VAL_W-1:0] reg_tone_low;
	logic [dai_pkg::VAL_W-1:0] reg_tone_high;
	logic [dai_pkg::CLK_W-1:0] reg_core_clock;

	// Alarm state kept by the predictor.
	logic                      st_alarm;
	logic [dai_pkg::VAL_W-1:0] st_period;
	logic [dai_pkg::MS_W-1:0]  st_last_toggle;
	logic                      st_phase;
	logic                      st_led;
	logic [dai_pkg::VAL_W-1:0] st_reload;
	logic [dai_pkg::CMP_W-1:0] st_compare;
	logic [dai_pkg::VAL_W-1:0] st_tone;

	alarm_outputs_t expected_outputs[$];
	logic [dai_pkg::MS_W-1:0] tick_clock;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned errors;

	dose_alarm_intensity_driver dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.alarm_request  (alarm_request),
		.measured_rate  (measured_rate),
		.dose_threshold (dose_threshold),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.alarm_active   (alarm_active),
		.led_lit        (led_lit),
		.tone_enable    (tone_enable),
		.reload_value   (reload_value),
		.compare_value  (compare_value),
		.blink_period_ms(blink_period_ms),
		.tone_hz        (tone_hz)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one item to the alarm state and return the outputs it leaves behind.
	function automatic alarm_outputs_t predict_outputs(input dose_event_t ev);
		logic [63:0] excess;
		logic [63:0] ratio;
		logic [63:0] quot;
		logic [dai_pkg::VAL_W-1:0] fast;
		logic [dai_pkg::VAL_W-1:0] high;
		logic [31:0] hz;
		alarm_outputs_t o;
		if (ev.act == dai_pkg::ACT_REFRESH) begin
			if (ev.req) begin
				// Excess ratio as a fraction, truncated; saturates at exactly one.
				ratio = '0;
				if (ev.thr != '0 && ev.rate > ev.thr) begin
					excess = 64'(ev.rate) - 64'(ev.thr);
					if (excess >= 64'(ev.thr))
						ratio = 64'd1 << dai_pkg::RATIO_FRAC_BITS;
					else
						ratio = (excess << dai_pkg::RATIO_FRAC_BITS) / 64'(ev.thr);
				end
				// The fast period never exceeds the slow one, the high tone never
				// falls below the low one.
				fast = (reg_fast > reg_slow) ? reg_slow : reg_fast;
				high = (reg_tone_high < reg_tone_low) ? reg_tone_low : reg_tone_high;
				quot = (64'(reg_slow - fast) * ratio) >> dai_pkg::RATIO_FRAC_BITS;
				st_period = reg_slow - quot[dai_pkg::VAL_W-1:0];
				quot = (64'(high - reg_tone_low) * ratio) >> dai_pkg::RATIO_FRAC_BITS;
				hz = 32'(reg_tone_low) + quot[31:0];
				if (hz < 32'(dai_pkg::TONE_MIN_HZ))
					hz = 32'(dai_pkg::TONE_MIN_HZ);
				st_tone = hz[dai_pkg::VAL_W-1:0];
				// Timer reload from the core clock; a zero quotient stays zero.
				quot = 64'(reg_core_clock) / 64'(hz);
				if (quot != '0)
					quot = quot - 64'd1;
				if (quot > 64'(dai_pkg::RELOAD_MAX))
					quot = 64'(dai_pkg::RELOAD_MAX);
				st_reload = quot[dai_pkg::VAL_W-1:0];
				st_compare = quot[dai_pkg::VAL_W-1:1];
				st_alarm = 1'b1;
			end else begin
				st_compare = '0;
				st_tone = '0;
				st_led = 1'b0;
				st_alarm = 1'b0;
				st_period = reg_slow;
			end
		end else if (!st_alarm) begin
			st_led = 1'b0;
			st_last_toggle = '0;
			st_phase = 1'b0;
		end else if (dai_pkg::MS_W'(ev.now - st_last_toggle) >= dai_pkg::MS_W'(st_period)) begin
			// Elapsed time wraps with the millisecond counter.
			st_last_toggle = ev.now;
			st_phase = !st_phase;
			st_led = st_phase;
		end
		o.alarm = st_alarm;
		o.led = st_led;
		o.tone_on = st_alarm;
		o.reload = st_reload;
		o.compare = st_compare;
		o.period = st_period;
		o.tone = st_tone;
		return o;
	endfunction

	function automatic dose_event_t make_event(input logic act, input logic req,
		input logic [dai_pkg::RATE_BITS-1:0] rate, input logic [dai_pkg::RATE_BITS-1:0] thr,
		input logic [dai_pkg::MS_W-1:0] now);
		dose_event_t ev;
		ev.act = act;
		ev.req = req;
		ev.rate = rate;
		ev.thr = thr;
		ev.now = now;
		return ev;
	endfunction

	// Mostly ticks stepping around the blink period, mixed with alarm refreshes,
	// with random jumps and backward steps of the millisecond time as noise.
	function automatic dose_event_t random_event();
		dose_event_t ev;
		int unsigned t;
		int unsigned r;
		int unsigned roll;
		ev.act = dai_pkg::ACT_TICK;
		ev.req = 1'($urandom);
		ev.rate = dai_pkg::RATE_BITS'($urandom);
		ev.thr = dai_pkg::RATE_BITS'($urandom);
		ev.now = $urandom;
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			ev.act = dai_pkg::ACT_REFRESH;
			ev.req = ($urandom_range(0, 99) < 85);
			t = ($urandom_range(0, 9) == 0) ? 0 :
				$urandom_range(1, 32'hFF_FFFF >> $urandom_range(0, 22));
			roll = $urandom_range(0, 9);
			if (roll < 2)
				r = $urandom_range(0, t);
			else if (roll < 4)
				r = (t <= 32'h7F_FFFF) ? $urandom_range(2 * t, 32'hFF_FFFF) : 32'hFF_FFFF;
			else if (roll < 9 && t >= 2 && t <= 32'h7F_FFFF)
				r = $urandom_range(t + 1, 2 * t - 1);
			else
				r = ev.rate;
			ev.rate = dai_pkg::RATE_BITS'(r);
			ev.thr = dai_pkg::RATE_BITS'(t);
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 85)
				tick_clock = tick_clock + $urandom_range(0, 2 * st_period + 2);
			else if (roll < 95)
				tick_clock = $urandom;
			else
				tick_clock = tick_clock - $urandom_range(1, 1000);
			ev.now = tick_clock;
		end
		return ev;
	endfunction

	// Present one item, hold it until accepted, then record what it should produce.
	task automatic send_item(input dose_event_t ev);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= ev.act;
		alarm_request <= ev.req;
		measured_rate <= ev.rate;
		dose_threshold <= ev.thr;
		now_ms <= ev.now;
		do
			@(posedge clk);
		while (in_stall);
		expected_outputs.push_back(predict_outputs(ev));
	endtask

	// Stop sending and wait until every outstanding result has been taken.
	task automatic drain_outputs();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_outputs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [dai_pkg::CFG_IDX_W-1:0] idx,
		input logic [dai_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dai_pkg::CFG_BLINK_SLOW: reg_slow = data[dai_pkg::VAL_W-1:0];
			dai_pkg::CFG_BLINK_FAST: reg_fast = data[dai_pkg::VAL_W-1:0];
			dai_pkg::CFG_TONE_LOW: reg_tone_low = data[dai_pkg::VAL_W-1:0];
			dai_pkg::CFG_TONE_HIGH: reg_tone_high = data[dai_pkg::VAL_W-1:0];
			dai_pkg::CFG_CORE_CLOCK: reg_core_clock = data;
			default: ;
		endcase
	endtask

	// Load a full setting once the block is idle. Unused upper data bits may
	// carry noise, and a write to an unmapped index must change nothing.
	task automatic apply_setting(input logic [dai_pkg::VAL_W-1:0] slow,
		input logic [dai_pkg::VAL_W-1:0] fast,
		input logic [dai_pkg::VAL_W-1:0] low, input logic [dai_pkg::VAL_W-1:0] high,
		input logic [dai_pkg::CLK_W-1:0] clock, input logic noisy);
		logic [dai_pkg::CFG_DATA_W-dai_pkg::VAL_W-1:0] pad;
		logic [dai_pkg::CFG_IDX_W-1:0] stray;
		drain_outputs();
		pad = noisy ? (dai_pkg::CFG_DATA_W - dai_pkg::VAL_W)'($urandom) : '0;
		write_register(dai_pkg::CFG_BLINK_SLOW, {pad, slow});
		write_register(dai_pkg::CFG_BLINK_FAST, {pad, fast});
		write_register(dai_pkg::CFG_TONE_LOW, {pad, low});
		write_register(dai_pkg::CFG_TONE_HIGH, {pad, high});
		write_register(dai_pkg::CFG_CORE_CLOCK, clock);
		stray = dai_pkg::CFG_IDX_W'($urandom_range(dai_pkg::CFG_CORE_CLOCK + 1,
			(1 << dai_pkg::CFG_IDX_W) - 1));
		write_register(stray, dai_pkg::CFG_DATA_W'($urandom));
	endtask

	// Ratio corner cases and silencing under the reset setting.
	task automatic test_ratio_and_silence();
		send_item(make_event(dai_pkg::ACT_TICK, 1'b1, '1, '1, 32'd5));
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'd100, 24'd0, '1));
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'd50, 24'd100, '0));
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'd150, 24'd100, '0));
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'd200, 24'd100, '0));
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'hFF_FFFF, 24'd1, '0));
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'hFF_FFFF, 24'hFF_FFFE, '0));
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b0, 24'hFF_FFFF, 24'hFF_FFFF, '1));
	endtask

	// Blink toggling at the period boundary, across the time wrap, and when idle.
	task automatic test_blink_timing();
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'd200, 24'd100, '0));
		send_item(make_event(dai_pkg::ACT_TICK, 1'b0, '0, '0, 32'd100));
		send_item(make_event(dai_pkg::ACT_TICK, 1'b0, '0, '0, 32'd150));
		send_item(make_event(dai_pkg::ACT_TICK, 1'b0, '0, '0, 32'd299));
		send_item(make_event(dai_pkg::ACT_TICK, 1'b0, '0, '0, 32'hFFFF_FFF0));
		send_item(make_event(dai_pkg::ACT_TICK, 1'b0, '0, '0, 32'h0000_0080));
		send_item(make_event(dai_pkg::ACT_TICK, 1'b0, '0, '0, 32'h0000_0086));
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b0, '0, '0, '0));
		send_item(make_event(dai_pkg::ACT_TICK, 1'b1, '1, '1, 32'h0000_0200));
	endtask

	// Register extremes: zero blink period, tone clamp, reload saturation,
	// swapped limits, and a core clock slower than the tone.
	task automatic test_register_extremes();
		apply_setting(16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 28'd200_000_000, 1'b0);
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'd200, 24'd100, '0));
		send_item(make_event(dai_pkg::ACT_TICK, 1'b0, '0, '0, 32'd7));
		send_item(make_event(dai_pkg::ACT_TICK, 1'b0, '0, '0, 32'd7));
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'd10, 24'd100, '0));
		apply_setting(16'd100, 16'd4000, 16'd9000, 16'd2000, 28'd50_000_000, 1'b0);
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'd150, 24'd100, '0));
		drain_outputs();
		write_register(dai_pkg::CFG_CORE_CLOCK, 28'd1000);
		send_item(make_event(dai_pkg::ACT_REFRESH, 1'b1, 24'd150, 24'd100, '0));
	endtask

	// Random traffic in six settings, moving through the idling modes.
	task automatic test_random_traffic();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: apply_setting(16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 28'd200_000_000, 1'b1);
				3: apply_setting(16'd1, 16'd0, 16'd1, 16'd1, 28'd1_000_000, 1'b1);
				5: apply_setting(dai_pkg::BLINK_SLOW_RST, dai_pkg::BLINK_FAST_RST,
					dai_pkg::TONE_LOW_RST, dai_pkg::TONE_HIGH_RST,
					dai_pkg::CORE_CLOCK_RST, 1'b0);
				default: apply_setting(
					dai_pkg::VAL_W'($urandom_range(1, 16'hFFFF >> $urandom_range(0, 12))),
					dai_pkg::VAL_W'($urandom_range(0, 16'hFFFF >> $urandom_range(0, 12))),
					dai_pkg::VAL_W'($urandom_range(1, 16'hFFFF >> $urandom_range(0, 4))),
					dai_pkg::VAL_W'($urandom_range(1, 16'hFFFF >> $urandom_range(0, 4))),
					dai_pkg::CLK_W'($urandom_range(1_000_000, 200_000_000)), 1'b1);
			endcase
			send_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 48 : 0;
			recv_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 7 : 0;
			repeat (117)
				send_item(random_event());
		end
	endtask

	// Receiver stalls at random.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : check_results
		alarm_outputs_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_outputs.size() == 0) begin
				$error("result item with no expectation waiting");
				errors++;
			end else begin
				want = expected_outputs.pop_front();
				check_field("alarm_active", 32'(want.alarm), 32'(alarm_active));
				check_field("led_lit", 32'(want.led), 32'(led_lit));
				check_field("tone_enable", 32'(want.tone_on), 32'(tone_enable));
				check_field("reload_value", 32'(want.reload), 32'(reload_value));
				check_field("compare_value", 32'(want.compare), 32'(compare_value));
				check_field("blink_period_ms", 32'(want.period), 32'(blink_period_ms));
				check_field("tone_hz", 32'(want.tone), 32'(tone_hz));
			end
		end
	end

	// Reset, run the tests in turn, then let the block settle.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = dai_pkg::ACT_REFRESH;
		alarm_request = 1'b0;
		measured_rate = '0;
		dose_threshold = '0;
		now_ms = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		errors = 0;
		tick_clock = '0;
		reg_slow = dai_pkg::BLINK_SLOW_RST;
		reg_fast = dai_pkg::BLINK_FAST_RST;
		reg_tone_low = dai_pkg::TONE_LOW_RST;
		reg_tone_high = dai_pkg::TONE_HIGH_RST;
		reg_core_clock = dai_pkg::CORE_CLOCK_RST;
		st_alarm = 1'b0;
		st_period = dai_pkg::BLINK_SLOW_RST;
		st_last_toggle = '0;
		st_phase = 1'b0;
		st_led = 1'b0;
		st_reload = dai_pkg::RELOAD_MAX;
		st_compare = '0;
		st_tone = '0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_ratio_and_silence();
		test_blink_timing();
		test_register_extremes();
		test_random_traffic();

		drain_outputs();
		repeat (100)
			@(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/dai_pkg.sv
hw/rtl/dai_divider.sv
hw/rtl/dose_alarm_intensity_driver.sv
tb/dose_alarm_intensity_driver_test.sv
